// ----- src/ssd_pkg.sv -----
`default_nettype none
// ============================================================================
// ssd_pkg - shared types and constants for the seven-segment scan driver
// Digit count, field widths, command kinds, glyph table and the command and
// status bundles passed between controller and datapath.
// ============================================================================
package ssd_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int DIG_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    localparam int KIND_W  = 2;
    localparam int NUM_W   = 16;
    localparam int BASE_W  = 5;
    localparam int POS_W   = 2;
    localparam int GLYPH_W = 5;
    localparam int SEG_W   = 8;
    localparam int SEL_W   = 8;
    localparam int WORD_W  = SEG_W + SEL_W;
    localparam int BIT_W   = $clog2(WORD_W);

    // quotient digit is at most 15, found one bit per cycle
    localparam int Q_W  = 4;
    localparam int QB_W = $clog2(Q_W);

    // largest power of the base that a digit weight can take is 16^(DIGIT_COUNT-1)
    localparam int POW_W = 4 * (DIGIT_COUNT - 1) + 1;
    localparam int CMP_W = (POW_W + Q_W > NUM_W + 1) ? POW_W + Q_W : NUM_W + 1;

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);

    localparam int GLYPH_COUNT = 18;
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'hff;
    localparam logic [SEG_W-1:0] SEG_DASH  = 8'hbf;

    localparam logic [SEG_W-1:0] GLYPH_TABLE [GLYPH_COUNT] = '{
        8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90,
        8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e, 8'hff, 8'hbf
    };

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 2'd0,
        KIND_NUMBER = 2'd1,
        KIND_GLYPH  = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef struct packed {
        logic             load_word;
        logic             load_num;
        logic             set_glyph;
        logic             clear_all;
        logic             pow_step;
        logic             write_dash;
        logic             div_step;
        logic             shift;
        logic             advance;
        logic [DIG_W-1:0] digit;
        logic [QB_W-1:0]  qbit;
    } t_cmd;

    typedef struct packed {
        logic overflow;
    } t_stat;

    function automatic logic [SEG_W-1:0] glyph_code(input logic [GLYPH_W-1:0] g);
        logic [SEG_W-1:0] code;
        if (int'(g) < GLYPH_COUNT) begin
            code = GLYPH_TABLE[g];
        end else begin
            code = SEG_BLANK;
        end
        return code;
    endfunction

endpackage
`default_nettype wire

// ----- src/ssd_ctrl.sv -----
`default_nettype none
// ============================================================================
// ssd_ctrl - sequencer for the seven-segment scan driver
// Steps the datapath through power build-up, overflow check, digit division
// and the serial shift-out of one scan transaction.
// ============================================================================
module ssd_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic [ssd_pkg::KIND_W-1:0] i_kind,
    input  wire logic                       i_out_ready,
    input  wire ssd_pkg::t_stat             i_stat,
    output ssd_pkg::t_cmd                   o_cmd,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    output logic                            o_latch_after
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POW,
        S_CHECK,
        S_DIV,
        S_SHIFT
    } t_state;

    localparam logic [ssd_pkg::DIG_W-1:0] DIG_LAST =
        ssd_pkg::DIG_W'(ssd_pkg::DIGIT_COUNT - 1);
    localparam logic [ssd_pkg::BIT_W-1:0] BIT_LAST =
        ssd_pkg::BIT_W'(ssd_pkg::WORD_W - 1);
    localparam logic [ssd_pkg::QB_W-1:0] QB_LAST = ssd_pkg::QB_W'(ssd_pkg::Q_W - 1);

    t_state                      r_state, n_state;
    logic [ssd_pkg::DIG_W-1:0]   r_digit, n_digit;
    logic [ssd_pkg::BIT_W-1:0]   r_cnt, n_cnt;

    always_comb begin
        n_state       = r_state;
        n_digit       = r_digit;
        n_cnt         = r_cnt;
        o_cmd         = '0;
        o_cmd.digit   = r_digit;
        o_cmd.qbit    = r_cnt[ssd_pkg::QB_W-1:0];
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_latch_after = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (ssd_pkg::t_kind'(i_kind))
                        ssd_pkg::KIND_TICK: begin
                            o_cmd.load_word = 1'b1;
                            n_cnt           = '0;
                            n_state         = S_SHIFT;
                        end
                        ssd_pkg::KIND_NUMBER: begin
                            o_cmd.load_num = 1'b1;
                            if (ssd_pkg::DIGIT_COUNT > 1) begin
                                n_digit = ssd_pkg::DIG_W'(1);
                                n_state = S_POW;
                            end else begin
                                n_state = S_CHECK;
                            end
                        end
                        ssd_pkg::KIND_GLYPH: begin
                            o_cmd.set_glyph = 1'b1;
                        end
                        ssd_pkg::KIND_CLEAR: begin
                            o_cmd.clear_all = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POW: begin
                o_cmd.pow_step = 1'b1;
                if (r_digit == DIG_LAST) begin
                    n_state = S_CHECK;
                end else begin
                    n_digit = r_digit + 1'b1;
                end
            end
            S_CHECK: begin
                if (i_stat.overflow) begin
                    o_cmd.write_dash = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_digit = '0;
                    n_cnt   = ssd_pkg::BIT_W'(QB_LAST);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt[ssd_pkg::QB_W-1:0] == '0) begin
                    if (r_digit == DIG_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_digit = r_digit + 1'b1;
                        n_cnt   = ssd_pkg::BIT_W'(QB_LAST);
                    end
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_SHIFT: begin
                o_out_valid   = 1'b1;
                o_latch_after = (r_cnt == BIT_LAST);
                if (i_out_ready) begin
                    o_cmd.shift = 1'b1;
                    if (r_cnt == BIT_LAST) begin
                        // last bit gone: move the scan to the next digit
                        o_cmd.advance = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_digit <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_digit <= n_digit;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ----- src/ssd_datapath.sv -----
`default_nettype none
// ============================================================================
// ssd_datapath - digit store, base conversion and shift register
// Holds the segment codes and scan position, builds the base powers with a
// small multiplier, extracts digits one quotient bit per cycle and shifts
// the segment/select word out MSB first.
// ============================================================================
module ssd_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ssd_pkg::t_cmd               i_cmd,
    input  wire logic [ssd_pkg::NUM_W-1:0]   i_number,
    input  wire logic [ssd_pkg::BASE_W-1:0]  i_base,
    input  wire logic [ssd_pkg::POS_W-1:0]   i_position,
    input  wire logic [ssd_pkg::GLYPH_W-1:0] i_glyph,
    output ssd_pkg::t_stat                   o_stat,
    output logic                             o_serial_bit
);

    localparam logic [ssd_pkg::DIG_W-1:0] DIG_LAST =
        ssd_pkg::DIG_W'(ssd_pkg::DIGIT_COUNT - 1);

    logic [ssd_pkg::SEG_W-1:0]   r_codes [ssd_pkg::DIGIT_COUNT];
    logic [ssd_pkg::DIG_W-1:0]   r_scan;
    logic [ssd_pkg::WORD_W-1:0]  r_word;
    logic [ssd_pkg::NUM_W-1:0]   r_rem;
    logic [ssd_pkg::BASE_W-1:0]  r_base;
    logic [ssd_pkg::POW_W-1:0]   r_acc;
    logic [ssd_pkg::POW_W-1:0]   r_pow [ssd_pkg::DIGIT_COUNT];
    logic [ssd_pkg::Q_W-1:0]     r_q;
    logic                        r_shown;

    logic [ssd_pkg::BASE_W-1:0]  base_clamped;
    logic [ssd_pkg::DIG_W-1:0]   pow_idx;
    logic [ssd_pkg::CMP_W-1:0]   rem_ext;
    logic [ssd_pkg::CMP_W-1:0]   sub;
    logic                        ge;
    logic [ssd_pkg::Q_W-1:0]     n_q;
    logic                        show;
    logic [ssd_pkg::SEL_W-1:0]   select;

    always_comb begin
        if (i_base < ssd_pkg::BASE_MIN) begin
            base_clamped = ssd_pkg::BASE_MIN;
        end else if (i_base > ssd_pkg::BASE_MAX) begin
            base_clamped = ssd_pkg::BASE_MAX;
        end else begin
            base_clamped = i_base;
        end
    end

    // leftmost digit uses the highest power
    assign pow_idx = DIG_LAST - i_cmd.digit;
    assign rem_ext = ssd_pkg::CMP_W'(r_rem);
    assign sub     = ssd_pkg::CMP_W'(r_pow[pow_idx]) << i_cmd.qbit;
    assign ge      = (rem_ext >= sub);
    assign n_q     = {r_q[ssd_pkg::Q_W-2:0], ge};
    assign show    = (n_q != '0) || r_shown || (i_cmd.digit == DIG_LAST);

    assign o_stat.overflow =
        rem_ext >= (ssd_pkg::CMP_W'(r_pow[DIG_LAST]) << ssd_pkg::Q_W);

    assign select = ssd_pkg::SEL_W'(1) << (DIG_LAST - r_scan);
    assign o_serial_bit = r_word[ssd_pkg::WORD_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ssd_pkg::DIGIT_COUNT; i++) begin
                r_codes[i] <= ssd_pkg::SEG_BLANK;
            end
            r_scan <= '0;
        end else begin
            if (i_cmd.clear_all) begin
                for (int i = 0; i < ssd_pkg::DIGIT_COUNT; i++) begin
                    r_codes[i] <= ssd_pkg::SEG_BLANK;
                end
            end
            if (i_cmd.write_dash) begin
                for (int i = 0; i < ssd_pkg::DIGIT_COUNT; i++) begin
                    r_codes[i] <= ssd_pkg::SEG_DASH;
                end
            end
            if (i_cmd.set_glyph && (int'(i_position) < ssd_pkg::DIGIT_COUNT)) begin
                r_codes[ssd_pkg::DIG_W'(i_position)] <= ssd_pkg::glyph_code(i_glyph);
            end
            if (i_cmd.div_step && (i_cmd.qbit == '0)) begin
                // blank leading zeros, always show the rightmost digit
                r_codes[i_cmd.digit] <= show ?
                    ssd_pkg::glyph_code(ssd_pkg::GLYPH_W'(n_q)) : ssd_pkg::SEG_BLANK;
            end
            if (i_cmd.advance) begin
                r_scan <= (r_scan == DIG_LAST) ? '0 : r_scan + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) begin
            r_word <= {r_codes[r_scan], select};
        end else if (i_cmd.shift) begin
            r_word <= r_word << 1;
        end
        if (i_cmd.load_num) begin
            r_rem    <= i_number;
            r_base   <= base_clamped;
            r_acc    <= ssd_pkg::POW_W'(base_clamped);
            r_pow[0] <= ssd_pkg::POW_W'(1);
            r_shown  <= 1'b0;
        end
        if (i_cmd.pow_step) begin
            r_pow[i_cmd.digit] <= r_acc;
            r_acc              <= ssd_pkg::POW_W'(r_acc * r_base);
        end
        if (i_cmd.div_step) begin
            r_q <= n_q;
            if (ge) begin
                r_rem <= ssd_pkg::NUM_W'(rem_ext - sub);
            end
            if ((i_cmd.qbit == '0) && show) begin
                r_shown <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/seven_segment_scan_driver.sv -----
`default_nettype none
// ============================================================================
// seven_segment_scan_driver - multiplexed four-digit seven-segment driver
// Keeps the segment codes of a common-anode display and shifts the current
// digit's segment and select bytes out to two chained shift registers.
// ============================================================================
// One transaction is taken at a time; o_in_ready is high only when idle.
// A scan tick, once accepted, presents 16 serial bits, one per cycle while
// the sink is ready; o_latch_after marks the sixteenth bit, after which the
// scan moves to the next digit.
// Show number runs through the accept cycle, DIGIT_COUNT - 1 multiplier
// steps that build the base powers, one overflow check, and a restoring
// divider that resolves each digit one quotient bit per cycle. When the
// leading digit overflows, dashes are written at the check and the command
// ends there. Set glyph and clear all finish in the accept cycle.
module seven_segment_scan_driver (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [ssd_pkg::KIND_W-1:0]  i_kind,
    input  wire logic [ssd_pkg::NUM_W-1:0]   i_number,
    input  wire logic [ssd_pkg::BASE_W-1:0]  i_base,
    input  wire logic [ssd_pkg::POS_W-1:0]   i_position,
    input  wire logic [ssd_pkg::GLYPH_W-1:0] i_glyph,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_serial_bit,
    output logic                             o_latch_after
);

    ssd_pkg::t_cmd  cmd;
    ssd_pkg::t_stat stat;

    ssd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_kind        (i_kind),
        .i_out_ready   (i_out_ready),
        .i_stat        (stat),
        .o_cmd         (cmd),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid),
        .o_latch_after (o_latch_after)
    );

    ssd_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_number     (i_number),
        .i_base       (i_base),
        .i_position   (i_position),
        .i_glyph      (i_glyph),
        .o_stat       (stat),
        .o_serial_bit (o_serial_bit)
    );

endmodule
`default_nettype wire

// ----- src/ssd_checker.sv -----
`default_nettype none
// ============================================================================
// ssd_checker - port-level checks for the seven-segment scan driver
// Watches the top-level handshakes and the shape of a scan transaction.
// ============================================================================
module ssd_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_ready,
    input wire logic [ssd_pkg::KIND_W-1:0]  i_kind,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic                        o_serial_bit,
    input wire logic                        o_latch_after
);

    // a stalled output bit holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_serial_bit) && $stable(o_latch_after))
        else $error("output bit changed while stalled");

    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_kind == ssd_pkg::KIND_TICK) |=> o_out_valid)
        else $error("scan tick did not start a shift-out");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken during shift-out");

    a_latch_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_latch_after |=> !o_out_valid)
        else $error("shift-out continued past the latch bit");

    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_latch_after |=> o_out_valid)
        else $error("shift-out stopped before the latch bit");

endmodule

bind seven_segment_scan_driver ssd_checker u_ssd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_kind        (i_kind),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_serial_bit  (o_serial_bit),
    .o_latch_after (o_latch_after)
);
`default_nettype wire
